// ===== sv/cmp_pkg.sv =====
// Package with the shared types, constants and table functions of the cross mean predictor.
package cmp_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_DOSAGE = 2'd0,
        OP_LOAD_EFFECT = 2'd1,
        OP_COMPUTE     = 2'd2,
        OP_NONE        = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        REG_PLOIDY  = 1'd0,
        REG_MARKERS = 1'd1
    } t_reg;

    localparam int TAB_W = 20;
    localparam int TAB_N = 3 * 7 * 7;

    typedef logic [TAB_N-1:0][TAB_W-1:0] t_tab;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic issue;
        logic last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
    } t_status;

    function automatic logic [2:0] ploidy_of(input logic [1:0] mode);
        logic [1:0] m;
        m = (mode > 2'd2) ? 2'd2 : mode;
        return {m, 1'b0} + 3'd2;
    endfunction

    // Gamete count for mode m (0..2), parent dosage i, gamete dosage k.
    function automatic int gcount(input int m, input int i, input int k);
        int r;
        r = 0;
        if (m == 0) begin
            if (i == 0 && k == 0) r = 2;
            if (i == 1 && k <= 1) r = 1;
            if (i == 2 && k == 1) r = 2;
        end else if (m == 1) begin
            unique case (i)
                0: r = (k == 0) ? 6 : 0;
                1: r = (k <= 1) ? 3 : 0;
                2: r = (k == 1) ? 4 : ((k == 0 || k == 2) ? 1 : 0);
                3: r = (k == 1 || k == 2) ? 3 : 0;
                4: r = (k == 2) ? 6 : 0;
                default: r = 0;
            endcase
        end else begin
            unique case (i)
                0: r = (k == 0) ? 20 : 0;
                1: r = (k <= 1) ? 10 : 0;
                2: r = (k == 1) ? 12 : ((k == 0 || k == 2) ? 4 : 0);
                3: r = (k == 1 || k == 2) ? 9 : 1;
                4: r = (k == 2) ? 12 : ((k == 1 || k == 3) ? 4 : 0);
                5: r = (k >= 2) ? 10 : 0;
                6: r = (k == 3) ? 20 : 0;
                default: r = 0;
            endcase
        end
        return r;
    endfunction

    // Quotient of a non-negative numerator by a positive denominator, by long division.
    function automatic longint udiv(input longint num, input longint den);
        longint q, r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            q = {q[62:0], 1'b0};
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint div_rnd(input longint num, input longint den);
        longint r;
        if (num >= 0) r = udiv(num + (den >>> 1), den);
        else r = -udiv(-num + (den >>> 1), den);
        return r;
    endfunction

    // Table entry in signed Q3.16 (20 bits); dom selects the dominance table.
    function automatic logic signed [TAB_W-1:0] tab_entry(input int m, input int i,
                                                         input int j, input bit dom);
        longint p, d, na, nd, w, n, v;
        p = 2 * (m + 1);
        d = (m == 0) ? 2 : ((m == 1) ? 6 : 20);
        na = 0;
        nd = 0;
        if (i <= p && j <= p) begin
            for (int k = 0; k <= 3; k++) begin
                for (int l = 0; l <= 3; l++) begin
                    w = gcount(m, i, k) * gcount(m, j, l);
                    n = k + l;
                    na += w * (2 * n - p);
                    nd += w * 4 * n * (p - n);
                end
            end
        end
        if (dom) v = div_rnd(nd * 65536, d * d * p * p);
        else v = div_rnd(na * 65536, d * d * p);
        return TAB_W'(v);
    endfunction

    // Whole table, entry index mode * 49 + dosage a * 7 + dosage b.
    function automatic t_tab build_tab(input bit dom);
        t_tab t;
        for (int m = 0; m < 3; m++)
            for (int i = 0; i < 7; i++)
                for (int j = 0; j < 7; j++)
                    t[m * 49 + i * 7 + j] = tab_entry(m, i, j, dom);
        return t;
    endfunction

    localparam t_tab ADD_TAB = build_tab(1'b0);
    localparam t_tab DOM_TAB = build_tab(1'b1);

endpackage

// ===== sv/cmp_ctrl.sv =====
// Controller state machine that sequences the marker walk of a compute request.
module cmp_ctrl #(
    parameter int MW = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MW:0]         i_count,
    input  cmp_pkg::t_status    i_status,
    input  logic                i_out_free,
    output cmp_pkg::t_cmd       o_cmd,
    output logic [MW-1:0]       o_marker,
    output logic                o_busy,
    output logic                o_result
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [MW:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.clear = 1'b1;
                    n_cnt = '0;
                    n_state = (i_count == '0) ? S_WAIT : S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                o_cmd.last  = (r_cnt + 1'b1 == i_count);
                n_cnt = r_cnt + 1'b1;
                if (o_cmd.last) n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_status.done || r_cnt == '0) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_marker = r_cnt[MW-1:0];
    assign o_busy   = (r_state != S_IDLE);
    assign o_result = (r_state == S_DONE) && i_out_free;

endmodule

// ===== sv/cmp_datapath.sv =====
// Datapath with the dosage and effect memories, table lookup, multipliers and accumulator.
module cmp_datapath #(
    parameter int NI = 64,
    parameter int NM = 1024,
    parameter int EF = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_dos_we,
    input  logic [$clog2(NI)-1:0]      i_dos_ind,
    input  logic [$clog2(NM)-1:0]      i_wr_marker,
    input  logic [2:0]                 i_dosage,
    input  logic                       i_eff_we,
    input  logic signed [23:0]         i_add,
    input  logic signed [23:0]         i_dom,
    input  logic [1:0]                 i_mode,
    input  logic [$clog2(NI)-1:0]      i_par_a,
    input  logic [$clog2(NI)-1:0]      i_par_b,
    input  logic                       i_a_ok,
    input  logic                       i_b_ok,
    input  logic [$clog2(NM)-1:0]      i_rd_marker,
    input  cmp_pkg::t_cmd              i_cmd,
    output cmp_pkg::t_status           o_status,
    output logic signed [63:0]         o_acc
);

    localparam int PW = cmp_pkg::TAB_W + 24;

    logic [2:0]  r_dos_mem [NI*NM];
    logic [47:0] r_eff_mem [NM];

    logic [2:0]  r_da, r_db;
    logic [47:0] r_eff;
    logic        r_v1, r_l1, r_v2, r_l2, r_v3, r_l3;
    logic        r_aok, r_bok;
    logic signed [PW-1:0] r_pa, r_pd;
    logic signed [65:0]   r_sum;
    logic signed [63:0]   r_acc;
    logic        r_done;

    // Port A: writes and parent a reads share one port; port B reads parent b.
    always_ff @(posedge i_clk) begin
        if (i_dos_we) r_dos_mem[{i_dos_ind, i_wr_marker}] <= i_dosage;
        r_da <= r_dos_mem[{i_par_a, i_rd_marker}];
    end
    always_ff @(posedge i_clk) begin
        r_db <= r_dos_mem[{i_par_b, i_rd_marker}];
    end
    always_ff @(posedge i_clk) begin
        if (i_eff_we) r_eff_mem[i_wr_marker] <= {i_add, i_dom};
        r_eff <= r_eff_mem[i_rd_marker];
    end

    logic [2:0] pl, da, db;
    logic [1:0] mi;
    logic [7:0] tix;
    logic signed [cmp_pkg::TAB_W-1:0] ta, td;
    logic signed [PW-1:0] pa_n, pd_n;
    logic signed [65:0] sa, sd;
    logic signed [65:0] tot;

    always_comb begin
        pl = cmp_pkg::ploidy_of(i_mode);
        mi = (i_mode > 2'd2) ? 2'd2 : i_mode;
        da = r_aok ? ((r_da > pl) ? pl : r_da) : 3'd0;
        db = r_bok ? ((r_db > pl) ? pl : r_db) : 3'd0;
        tix = 8'(mi) * 8'd49 + 8'(da) * 8'd7 + 8'(db);
        ta = cmp_pkg::ADD_TAB[tix];
        td = cmp_pkg::DOM_TAB[tix];
        pa_n = PW'(ta) * PW'($signed(r_eff[47:24]));
        pd_n = PW'(td) * PW'($signed(r_eff[23:0]));
    end

    always_comb begin
        if (EF <= 16) begin
            sa = 66'(r_pa) <<< (16 - EF);
            sd = 66'(r_pd) <<< (16 - EF);
        end else begin
            sa = 66'(r_pa) >>> (EF - 16);
            sd = 66'(r_pd) >>> (EF - 16);
        end
        tot = 66'(r_acc) + r_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_l1 <= 1'b0; r_l2 <= 1'b0; r_l3 <= 1'b0;
            r_acc <= '0;
            r_done <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_l1 <= i_cmd.last;
            r_v2 <= r_v1;
            r_l2 <= r_l1;
            r_v3 <= r_v2;
            r_l3 <= r_l2;
            r_done <= r_v3 && r_l3;
            if (i_cmd.clear) begin
                r_acc <= '0;
            end else if (r_v3) begin
                if (tot > 66'sh0_7FFF_FFFF_FFFF_FFFF) r_acc <= 64'h7FFF_FFFF_FFFF_FFFF;
                else if (tot < -66'sh0_8000_0000_0000_0000) r_acc <= 64'h8000_0000_0000_0000;
                else r_acc <= tot[63:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_aok <= i_a_ok;
        r_bok <= i_b_ok;
        r_pa  <= pa_n;
        r_pd  <= pd_n;
        r_sum <= sa + sd;
    end

    assign o_status.done = r_done;
    assign o_acc = r_acc;

endmodule

// ===== sv/cross_mean_predictor_core.sv =====
// Top level of the cross mean predictor: ports, request decode, controller and datapath.
//  Channel | Direction | Handshake              | Payload
//  cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid/o_in_ready   | op, parents, marker, dosage, effects
//  out     | out       | o_out_valid/i_out_ready | parent numbers, cross mean
// A load is written into its memory when it is accepted. A compute request walks the markers
// in use, one marker per cycle, through the memory read, multiply and accumulate stages, and
// shows its result on the output channel once the last marker is accumulated.
// Reset is synchronous and active low; the memories hold no reset value.
// The input is refused during a whole compute, and a finished compute waits for a held result.
module cross_mean_predictor_core #(
    parameter int MAX_INDIVIDUALS  = 64,
    parameter int MAX_MARKERS      = 1024,
    parameter int EFFECT_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [0:0]         i_cfg_index,
    input  logic [10:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  logic [5:0]         i_ind_a,
    input  logic [5:0]         i_ind_b,
    input  logic [9:0]         i_marker,
    input  logic [2:0]         i_dosage,
    input  logic signed [23:0] i_additive_effect,
    input  logic signed [23:0] i_dominance_effect,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [6:0]         o_first_parent_number,
    output logic [6:0]         o_second_parent_number,
    output logic signed [63:0] o_cross_mean
);

    localparam int IW = $clog2(MAX_INDIVIDUALS);
    localparam int MW = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
    localparam int NMD = 2 ** MW;

    logic [1:0]  r_mode;
    logic [10:0] r_mic;
    logic [5:0]  r_pa, r_pb;
    logic        r_ov;
    logic [6:0]  r_fp, r_sp;
    logic signed [63:0] r_cm;

    cmp_pkg::t_cmd    cmd;
    cmp_pkg::t_status st;
    logic [MW-1:0] rd_mk;
    logic busy, result, acc_in;
    logic [MW:0] count;
    logic signed [63:0] acc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !busy;
    assign acc_in      = i_in_valid && o_in_ready;

    always_comb begin
        if (32'(r_mic) > MAX_MARKERS) count = (MW+1)'(MAX_MARKERS);
        else count = (MW+1)'(r_mic);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'd0;
            r_mic  <= 11'd1024;
        end else if (i_cfg_valid) begin
            unique case (cmp_pkg::t_reg'(i_cfg_index))
                cmp_pkg::REG_PLOIDY:  r_mode <= i_cfg_data[1:0];
                cmp_pkg::REG_MARKERS: r_mic  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in && i_op == cmp_pkg::OP_COMPUTE) begin
            r_pa <= i_ind_a;
            r_pb <= i_ind_b;
        end
    end

    logic start;
    logic dos_we, eff_we;
    logic [2:0] pl;
    assign start  = acc_in && (i_op == cmp_pkg::OP_COMPUTE);
    assign pl     = cmp_pkg::ploidy_of(r_mode);
    assign dos_we = acc_in && i_op == cmp_pkg::OP_LOAD_DOSAGE
                    && 32'(i_ind_a) < MAX_INDIVIDUALS && 32'(i_marker) < MAX_MARKERS;
    assign eff_we = acc_in && i_op == cmp_pkg::OP_LOAD_EFFECT
                    && 32'(i_marker) < MAX_MARKERS;

    cmp_ctrl #(.MW(MW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_count(count),
        .i_status(st), .i_out_free(!r_ov || i_out_ready), .o_cmd(cmd),
        .o_marker(rd_mk), .o_busy(busy), .o_result(result)
    );

    cmp_datapath #(.NI(2 ** IW), .NM(NMD), .EF(EFFECT_FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_dos_we(dos_we), .i_dos_ind(IW'(i_ind_a)), .i_wr_marker(MW'(i_marker)),
        .i_dosage((i_dosage > pl) ? pl : i_dosage),
        .i_eff_we(eff_we), .i_add(i_additive_effect), .i_dom(i_dominance_effect),
        .i_mode(r_mode), .i_par_a(IW'(r_pa)), .i_par_b(IW'(r_pb)),
        .i_a_ok(32'(r_pa) < MAX_INDIVIDUALS), .i_b_ok(32'(r_pb) < MAX_INDIVIDUALS),
        .i_rd_marker(rd_mk), .i_cmd(cmd), .o_status(st), .o_acc(acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (result) r_ov <= 1'b1;
        else if (i_out_ready) r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (result) begin
            r_fp <= 7'(r_pa) + 7'd1;
            r_sp <= 7'(r_pb) + 7'd1;
            r_cm <= acc;
        end
    end

    assign o_out_valid            = r_ov;
    assign o_first_parent_number  = r_fp;
    assign o_second_parent_number = r_sp;
    assign o_cross_mean           = r_cm;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_in_ready) else $error("input accepted while busy");
    a_result_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result |-> (!r_ov || i_out_ready)) else $error("result overwrote a held one");
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> busy) else $error("compute did not start");

endmodule
